/* rtl/core/vector_cosine_overlap_defines.svh */
// Assertion macros shared by the vector_cosine_overlap RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef VECTOR_COSINE_OVERLAP_DEFINES_SVH
`define VECTOR_COSINE_OVERLAP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define VCO_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define VCO_ASSERT_NXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/vco_pkg.sv */
// Types and constants for the vector cosine overlap block.
// No dependencies; imported by every other file of the block but the macro header.
`timescale 1ns / 1ps
`default_nettype none

package vco_pkg;

    localparam int ELEM_W    = 16;                 // Q1.15 element
    localparam int SQ_W      = 2 * ELEM_W - 1;     // a*a <= 2^30
    localparam int DOT_W     = 44;
    localparam int NORM_W    = 43;
    localparam int MAG_W     = 44;                 // |dot| up to 2^43
    localparam int LIMB_W    = MAG_W / 2;
    localparam int PP_W      = 2 * LIMB_W;
    localparam int WIDE_W    = 2 * MAG_W;
    localparam int FRAC_SH   = 30;                 // Q2.30 -> Q1.15 squared
    localparam int DIV_STEPS = WIDE_W + FRAC_SH;
    localparam int MUL_STEPS = 8;                  // 2 products x 4 partials
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int ROOT_W    = 15;
    localparam int RES_W     = 16;

    localparam logic [RES_W-1:0] ONE_Q15 = {1'b1, {(RES_W-1){1'b0}}};

    typedef struct packed {
        logic [MAG_W-1:0]  mag;
        logic [NORM_W-1:0] norm_a;
        logic [NORM_W-1:0] norm_b;
        logic              degen;
        logic              sat;
    } vco_job_t;

    typedef struct packed {
        logic     valid;
        vco_job_t job;
    } vco_push_t;

    typedef struct packed {
        logic full;
        logic one_left;
        logic empty;
    } vco_qstat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_ROOT,
        ST_OUT
    } vco_state_t;

endpackage

`default_nettype wire

/* rtl/core/vco_in_if.sv */
// Input channel: one element pair of the two vectors per item.
// Depends on vco_pkg for the element width.
`timescale 1ns / 1ps
`default_nettype none

interface vco_in_if import vco_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] elem_a;
    logic signed [ELEM_W-1:0] elem_b;
    logic                     last;

    modport source (output valid, output elem_a, output elem_b, output last, input ready);
    modport sink (input valid, input elem_a, input elem_b, input last, output ready);

endinterface

`default_nettype wire

/* rtl/core/vco_out_if.sv */
// Output channel: one overlap result item per vector pair.
// Depends on vco_pkg for the result width.
`timescale 1ns / 1ps
`default_nettype none

interface vco_out_if import vco_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [RES_W-1:0] overlap;
    logic             degenerate;
    logic             overflowed;

    modport source (output valid, output overlap, output degenerate, output overflowed,
                    input ready);
    modport sink (input valid, input overlap, input degenerate, input overflowed,
                  output ready);

endinterface

`default_nettype wire

/* rtl/core/vco_front.sv */
// Front end: element products, saturating running sums, job hand-off on last.
// Depends on vco_pkg and vco_in_if.
`timescale 1ns / 1ps
`default_nettype none

module vco_front import vco_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    vco_in_if.sink     samples,
    input  vco_qstat_t qstat,
    output vco_push_t  push
);

    localparam logic [DOT_W-1:0]  DOT_MAX  = {1'b0, {(DOT_W-1){1'b1}}};
    localparam logic [DOT_W-1:0]  DOT_MIN  = {1'b1, {(DOT_W-1){1'b0}}};
    localparam logic [NORM_W-1:0] NORM_MAX = {NORM_W{1'b1}};

    logic                       s1_valid_reg;
    logic                       s1_last_reg;
    logic [2*ELEM_W-1:0]        s1_prod_reg;
    logic [SQ_W-1:0]            s1_sq_a_reg;
    logic [SQ_W-1:0]            s1_sq_b_reg;

    logic [DOT_W-1:0]           dot_sum_reg, dot_sum_next;
    logic [NORM_W-1:0]          norm_a_sum_reg, norm_a_sum_next;
    logic [NORM_W-1:0]          norm_b_sum_reg, norm_b_sum_next;
    logic                       sat_flag_reg, sat_flag_next;

    logic signed [2*ELEM_W-1:0] prod_ab;
    logic signed [2*ELEM_W-1:0] prod_aa;
    logic signed [2*ELEM_W-1:0] prod_bb;
    logic                       accept;

    logic [DOT_W:0]             dot_wide;
    logic [NORM_W:0]            na_wide;
    logic [NORM_W:0]            nb_wide;
    logic [DOT_W-1:0]           dot_sat;
    logic [NORM_W-1:0]          na_sat;
    logic [NORM_W-1:0]          nb_sat;
    logic                       sat_any;

    // a last item still in the product stage will take a queue slot
    assign samples.ready = !qstat.full && !(qstat.one_left && s1_valid_reg && s1_last_reg);
    assign accept        = samples.valid && samples.ready;

    assign prod_ab = samples.elem_a * samples.elem_b;
    assign prod_aa = samples.elem_a * samples.elem_a;
    assign prod_bb = samples.elem_b * samples.elem_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg <= samples.last;
            s1_prod_reg <= prod_ab;
            s1_sq_a_reg <= prod_aa[SQ_W-1:0];
            s1_sq_b_reg <= prod_bb[SQ_W-1:0];
        end
    end

    always_comb
    begin
        dot_wide = {dot_sum_reg[DOT_W-1], dot_sum_reg}
                 + {{(DOT_W+1-2*ELEM_W){s1_prod_reg[2*ELEM_W-1]}}, s1_prod_reg};
        na_wide  = {1'b0, norm_a_sum_reg} + {{(NORM_W+1-SQ_W){1'b0}}, s1_sq_a_reg};
        nb_wide  = {1'b0, norm_b_sum_reg} + {{(NORM_W+1-SQ_W){1'b0}}, s1_sq_b_reg};

        if (dot_wide[DOT_W] != dot_wide[DOT_W-1])
        begin
            dot_sat = dot_wide[DOT_W] ? DOT_MIN : DOT_MAX;
        end
        else
        begin
            dot_sat = dot_wide[DOT_W-1:0];
        end
        na_sat  = na_wide[NORM_W] ? NORM_MAX : na_wide[NORM_W-1:0];
        nb_sat  = nb_wide[NORM_W] ? NORM_MAX : nb_wide[NORM_W-1:0];
        sat_any = (dot_wide[DOT_W] != dot_wide[DOT_W-1]) || na_wide[NORM_W] || nb_wide[NORM_W];

        dot_sum_next    = dot_sum_reg;
        norm_a_sum_next = norm_a_sum_reg;
        norm_b_sum_next = norm_b_sum_reg;
        sat_flag_next   = sat_flag_reg;
        if (s1_valid_reg)
        begin
            if (s1_last_reg)
            begin
                dot_sum_next    = '0;
                norm_a_sum_next = '0;
                norm_b_sum_next = '0;
                sat_flag_next   = 1'b0;
            end
            else
            begin
                dot_sum_next    = dot_sat;
                norm_a_sum_next = na_sat;
                norm_b_sum_next = nb_sat;
                sat_flag_next   = sat_flag_reg || sat_any;
            end
        end
    end

    always_comb
    begin
        push.valid      = s1_valid_reg && s1_last_reg;
        push.job.mag    = dot_sat[DOT_W-1] ? (~dot_sat + 1'b1) : dot_sat;
        push.job.norm_a = na_sat;
        push.job.norm_b = nb_sat;
        push.job.degen  = (na_sat == '0) || (nb_sat == '0);
        push.job.sat    = sat_flag_reg || sat_any;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_sum_reg    <= '0;
            norm_a_sum_reg <= '0;
            norm_b_sum_reg <= '0;
            sat_flag_reg   <= 1'b0;
        end
        else
        begin
            dot_sum_reg    <= dot_sum_next;
            norm_a_sum_reg <= norm_a_sum_next;
            norm_b_sum_reg <= norm_b_sum_next;
            sat_flag_reg   <= sat_flag_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/vco_queue.sv */
// Short job queue between front end and back end.
// Depends on vco_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vco_queue import vco_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  vco_push_t  push,
    input  logic       pop,
    output vco_qstat_t qstat,
    output vco_job_t   head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    vco_job_t         entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.valid && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push.valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entries_reg[wr_ptr_reg] <= push.job;
        end
    end

    assign head           = entries_reg[rd_ptr_reg];
    assign qstat.full     = (count_reg == CNT_W'(DEPTH));
    assign qstat.one_left = (count_reg == CNT_W'(DEPTH - 1));
    assign qstat.empty    = (count_reg == '0);

endmodule

`default_nettype wire

/* rtl/core/vco_back.sv */
// Back end sequencer: wide products, restoring divide, integer root, result register.
// Depends on vco_pkg and vco_out_if.
`timescale 1ns / 1ps
`default_nettype none

module vco_back import vco_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  vco_qstat_t qstat,
    input  vco_job_t   head,
    output logic       pop,
    vco_out_if.source  result
);

    vco_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg;
    vco_job_t          job_reg;
    logic [PP_W-1:0]   pp_reg;
    logic [2:0]        pp_tag_reg;
    logic [WIDE_W-1:0] p_reg;      // norm_a * norm_b
    logic [WIDE_W-1:0] m_reg;      // mag^2, then dividend shifter
    logic [WIDE_W-1:0] rem_reg;
    logic [FRAC_SH-1:0] quo_reg;
    logic              big_reg;    // quotient reached 2^30
    logic [ROOT_W-1:0] root_reg;

    logic              out_valid_reg;
    logic [RES_W-1:0]  out_overlap_reg;
    logic              out_degen_reg;
    logic              out_ovf_reg;

    logic              out_load;
    logic              mul_done;
    logic              div_done;
    logic              root_done;

    logic [2:0]        tag;
    logic [MAG_W-1:0]  op_x;
    logic [MAG_W-1:0]  op_y;
    logic [LIMB_W-1:0] limb_x;
    logic [LIMB_W-1:0] limb_y;
    logic [PP_W-1:0]   pp_next;
    logic [WIDE_W-1:0] pp_shifted;

    logic [WIDE_W-1:0] trial;
    logic [WIDE_W:0]   diff;

    logic [3:0]        root_pos;
    logic [ROOT_W-1:0] cand;
    logic [2*ROOT_W-1:0] cand_sq;
    logic [RES_W-1:0]  overlap_val;

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!qstat.empty)
                begin
                    state_next = head.degen ? ST_OUT : ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (root_done || big_reg)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb
    begin
        pop       = 1'b0;
        out_load  = 1'b0;
        mul_done  = 1'b0;
        div_done  = 1'b0;
        root_done = 1'b0;
        case (state_reg)
            ST_IDLE: pop       = !qstat.empty;
            ST_MUL:  mul_done  = (step_reg == STEP_W'(MUL_STEPS));
            ST_DIV:  div_done  = (step_reg == STEP_W'(DIV_STEPS - 1));
            ST_ROOT: root_done = (step_reg == STEP_W'(ROOT_W - 1));
            ST_OUT:  out_load  = !out_valid_reg || result.ready;
            default: pop       = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------- datapath ----------------
    // 22x22 partial products; tag bit 2 picks the mag^2 pass
    always_comb
    begin
        tag     = step_reg[2:0];
        op_x    = tag[2] ? job_reg.mag : {1'b0, job_reg.norm_a};
        op_y    = tag[2] ? job_reg.mag : {1'b0, job_reg.norm_b};
        limb_x  = tag[1] ? op_x[MAG_W-1:LIMB_W] : op_x[LIMB_W-1:0];
        limb_y  = tag[0] ? op_y[MAG_W-1:LIMB_W] : op_y[LIMB_W-1:0];
        pp_next = limb_x * limb_y;

        case (pp_tag_reg[1:0])
            2'b00:   pp_shifted = WIDE_W'(pp_reg);
            2'b11:   pp_shifted = WIDE_W'(pp_reg) << (2 * LIMB_W);
            default: pp_shifted = WIDE_W'(pp_reg) << LIMB_W;
        endcase
    end

    always_comb
    begin
        trial = {rem_reg[WIDE_W-2:0], m_reg[WIDE_W-1]};
        diff  = {1'b0, trial} - {1'b0, p_reg};
    end

    always_comb
    begin
        root_pos    = 4'(ROOT_W - 1) - step_reg[3:0];
        cand        = root_reg | (ROOT_W'(1) << root_pos);
        cand_sq     = cand * cand;
        if (job_reg.degen)
        begin
            overlap_val = '0;
        end
        else if (big_reg)
        begin
            overlap_val = ONE_Q15;
        end
        else
        begin
            overlap_val = {1'b0, root_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (pop || mul_done || div_done || root_done)
        begin
            step_reg <= '0;
        end
        else if (state_reg == ST_MUL || state_reg == ST_DIV || state_reg == ST_ROOT)
        begin
            step_reg <= step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    job_reg  <= head;
                    p_reg    <= '0;
                    m_reg    <= '0;
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    big_reg  <= 1'b0;
                    root_reg <= '0;
                end
            end
            ST_MUL:
            begin
                if (step_reg != '0)
                begin
                    if (pp_tag_reg[2])
                    begin
                        m_reg <= m_reg + pp_shifted;
                    end
                    else
                    begin
                        p_reg <= p_reg + pp_shifted;
                    end
                end
                if (!mul_done)
                begin
                    pp_reg     <= pp_next;
                    pp_tag_reg <= tag;
                end
            end
            ST_DIV:
            begin
                m_reg <= m_reg << 1;
                if (!diff[WIDE_W])
                begin
                    rem_reg <= diff[WIDE_W-1:0];
                end
                else
                begin
                    rem_reg <= trial;
                end
                quo_reg <= {quo_reg[FRAC_SH-2:0], !diff[WIDE_W]};
                big_reg <= big_reg || quo_reg[FRAC_SH-1];
            end
            ST_ROOT:
            begin
                if (cand_sq <= quo_reg)
                begin
                    root_reg <= cand;
                end
            end
            default:
            begin
                job_reg <= job_reg;
            end
        endcase
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_overlap_reg <= overlap_val;
            out_degen_reg   <= job_reg.degen;
            out_ovf_reg     <= job_reg.sat;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.overlap    = out_overlap_reg;
    assign result.degenerate = out_degen_reg;
    assign result.overflowed = out_ovf_reg;

endmodule

`default_nettype wire

/* rtl/core/vector_cosine_overlap.sv */
// Flow: after hand-off through the job queue, a last item's job passes the product,
// divide and root steps of the back end; a degenerate vector pair skips all three.
// Throughput: one element pair per cycle while the job queue has room; the bit-serial
// restoring divide and root hold one job at a time; a clamp to 1.0 ends the root early.
// Reset: rst_n asynchronous, active low; clears sums, queue and sequencer, no sweep.
`timescale 1ns / 1ps
`default_nettype none
`include "vector_cosine_overlap_defines.svh"

module vector_cosine_overlap import vco_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      clk,
    input  logic      rst_n,
    vco_in_if.sink    samples,
    vco_out_if.source result
);

    vco_push_t  push;
    vco_qstat_t qstat;
    vco_job_t   head;
    logic       pop;

    vco_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .qstat   (qstat),
        .push    (push)
    );

    vco_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .qstat (qstat),
        .head  (head)
    );

    vco_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .qstat  (qstat),
        .head   (head),
        .pop    (pop),
        .result (result)
    );

    // credit check: a job never arrives at a full queue
    `VCO_ASSERT_IMP(a_push_room, clk, rst_n, push.valid, !qstat.full, "job pushed into full queue")
    `VCO_ASSERT_IMP(a_stall_cause, clk, rst_n, !samples.ready, qstat.full || qstat.one_left,
                    "input stalled with queue room")
    `VCO_ASSERT_IMP(a_degen_zero, clk, rst_n, result.valid && result.degenerate,
                    result.overlap == '0, "degenerate result with nonzero overlap")
    `VCO_ASSERT_NXT(a_empty_stays, clk, rst_n, qstat.empty && !push.valid, qstat.empty,
                    "queue left empty without a push")

endmodule

`default_nettype wire
